@@ rtl/nmeafx_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the NMEA field extractor.
package nmeafx_pkg;

  typedef logic [7:0] char_t;

  // Quantity codes carried on the result channel.
  typedef enum logic [2:0] {
    Q_GROUND_SPEED = 3'd0,
    Q_COURSE       = 3'd1,
    Q_RANGE        = 3'd2,
    Q_CLOSING_VEL  = 3'd3,
    Q_HEADING      = 3'd4
  } quantity_t;

  // Running state of the decimal-to-fixed-point conversion of one field.
  typedef struct packed {
    logic [31:0] mag;           // absolute value in thousandths, saturates at 2^31
    logic [1:0]  frac_cnt;      // fraction digits taken so far
    logic        frac_started;  // a dot has been seen
    logic        neg;           // a leading minus sign has been seen
    logic        stopped;       // an invalid character ended conversion
    logic        chars;         // the field holds at least one character
  } conv_t;

  localparam logic [2:0]  PrefixLen = 3'd6;
  localparam logic [3:0]  FieldMax  = 4'd15;
  localparam logic [31:0] MagLimit  = 32'h8000_0000;
  localparam logic [31:0] PosLimit  = 32'h7FFF_FFFF;

  localparam logic [47:0] PrefixRmc = "$GPRMC";
  localparam logic [47:0] PrefixRmb = "$ECRMB";
  localparam logic [47:0] PrefixApb = "$ECAPB";

  localparam char_t ChComma = ",";
  localparam char_t ChDot   = ".";
  localparam char_t ChPlus  = "+";
  localparam char_t ChMinus = "-";
  localparam char_t ChZero  = "0";
  localparam char_t ChNine  = "9";

  // Character at a position of a six-character prefix, first character first.
  function automatic char_t prefix_char(input logic [47:0] text, input logic [2:0] pos);
    char_t c;
    case (pos)
      3'd0:    c = text[47:40];
      3'd1:    c = text[39:32];
      3'd2:    c = text[31:24];
      3'd3:    c = text[23:16];
      3'd4:    c = text[15:8];
      default: c = text[7:0];
    endcase
    return c;
  endfunction

endpackage

@@ rtl/nmeafx_in_if.sv @@
`timescale 1ns / 1ps
// Input channel interface: one sentence character per transaction.
interface nmeafx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

@@ rtl/nmeafx_out_if.sv @@
`timescale 1ns / 1ps
// Result channel interface: one extracted field value per transaction.
interface nmeafx_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         quantity;
  logic signed [31:0] fixed_value;

  modport source (output valid, output quantity, output fixed_value, input ready);
  modport sink   (input valid, input quantity, input fixed_value, output ready);
endinterface

@@ rtl/nmeafx_conv.sv @@
`timescale 1ns / 1ps
// Next-state logic of the decimal text to fixed-point conversion of one character.
module nmeafx_conv (
  input  nmeafx_pkg::char_t data_byte,
  input  nmeafx_pkg::conv_t cur,
  output nmeafx_pkg::conv_t nxt
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] int_sum;
  logic [32:0] frac_sum;
  logic [9:0]  frac_weight;

  assign is_digit = (data_byte >= nmeafx_pkg::ChZero) && (data_byte <= nmeafx_pkg::ChNine);
  assign digit    = 4'(data_byte - nmeafx_pkg::ChZero);

  // Integer digit: mag*10 + d*1000, with mag*10 formed as two shifts.
  assign int_sum = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0}
                 + 36'(digit) * 36'd1000;

  always_comb begin
    case (cur.frac_cnt)
      2'd0:    frac_weight = 10'd100;
      2'd1:    frac_weight = 10'd10;
      default: frac_weight = 10'd1;
    endcase
  end

  assign frac_sum = {1'b0, cur.mag} + 33'(14'(digit) * 14'(frac_weight));

  always_comb begin
    nxt       = cur;
    nxt.chars = 1'b1;
    if (!cur.stopped) begin
      if (is_digit) begin
        if (!cur.frac_started) begin
          nxt.mag = (int_sum > 36'(nmeafx_pkg::MagLimit)) ? nmeafx_pkg::MagLimit
                                                          : int_sum[31:0];
        end else if (cur.frac_cnt != 2'd3) begin
          nxt.mag      = (frac_sum > 33'(nmeafx_pkg::MagLimit)) ? nmeafx_pkg::MagLimit
                                                                : frac_sum[31:0];
          nxt.frac_cnt = cur.frac_cnt + 2'd1;
        end
      end else if ((data_byte == nmeafx_pkg::ChPlus || data_byte == nmeafx_pkg::ChMinus)
                   && !cur.chars) begin
        nxt.neg = (data_byte == nmeafx_pkg::ChMinus);
      end else if (data_byte == nmeafx_pkg::ChDot && !cur.frac_started) begin
        nxt.frac_started = 1'b1;
      end else begin
        nxt.stopped = 1'b1;
      end
    end
  end

endmodule

@@ rtl/nmea_sentence_field_extractor_core.sv @@
`timescale 1ns / 1ps
// Top level of the NMEA sentence field extractor.

// The core takes an NMEA sentence one character per input transaction, with
// end_of_packet marking the last character, after which all parsing state
// returns to its reset value. The first six characters must be $GPRMC, $ECRMB
// or $ECAPB; any other prefix makes the core ignore the rest of the packet.
// Fields are counted by commas, and the chosen fields (RMC 7 and 8, RMB 10 and
// 12, APB 13) are converted from decimal text to signed fixed point in
// thousandths, saturated to the 32-bit limits. A result transaction is issued
// when a chosen field is closed by a comma; a field closed by the end of the
// packet gives no result, and an empty field gives zero. The core takes one
// input transaction per clock cycle for as long as the result register is
// empty or being drained in the same cycle; the result is valid in the cycle
// after the closing comma is accepted. Only a result waiting on a stalled
// output holds the input side back.
module nmea_sentence_field_extractor_core (
  input  logic                clk,
  input  logic                rst_n,
  nmeafx_in_if.sink           in_chan,
  nmeafx_out_if.source        out_chan
);

  logic [2:0]            prefix_pos_r, prefix_pos_nxt;
  logic [2:0]            cands_r, cands_nxt;
  logic [3:0]            field_r, field_nxt;
  nmeafx_pkg::conv_t     conv_r, conv_nxt, conv_step;

  logic                  out_valid_r, out_valid_nxt;
  nmeafx_pkg::quantity_t out_qty_r, out_qty_nxt;
  logic [31:0]           out_val_r, out_val_nxt;

  logic                  in_fire;
  logic                  qty_hit;
  nmeafx_pkg::quantity_t qty_sel;
  logic [31:0]           signed_bits;

  // The core accepts a character whenever the result register can take a
  // new value in the same cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  nmeafx_conv u_conv (
    .data_byte (in_chan.data_byte),
    .cur       (conv_r),
    .nxt       (conv_step)
  );

  // Which quantity, if any, the current field carries. The lowest surviving
  // prefix candidate decides.
  always_comb begin
    qty_hit = 1'b0;
    qty_sel = nmeafx_pkg::Q_GROUND_SPEED;
    if (cands_r[0]) begin
      if (field_r == 4'd7) begin
        qty_hit = 1'b1;
        qty_sel = nmeafx_pkg::Q_GROUND_SPEED;
      end else if (field_r == 4'd8) begin
        qty_hit = 1'b1;
        qty_sel = nmeafx_pkg::Q_COURSE;
      end
    end else if (cands_r[1]) begin
      if (field_r == 4'd10) begin
        qty_hit = 1'b1;
        qty_sel = nmeafx_pkg::Q_RANGE;
      end else if (field_r == 4'd12) begin
        qty_hit = 1'b1;
        qty_sel = nmeafx_pkg::Q_CLOSING_VEL;
      end
    end else if (cands_r[2]) begin
      if (field_r == 4'd13) begin
        qty_hit = 1'b1;
        qty_sel = nmeafx_pkg::Q_HEADING;
      end
    end
  end

  // A negative value is the two's complement of the magnitude; a positive one
  // is clamped to the largest positive value.
  assign signed_bits = conv_r.neg ? (32'd0 - conv_r.mag)
                     : ((conv_r.mag > nmeafx_pkg::PosLimit) ? nmeafx_pkg::PosLimit
                                                            : conv_r.mag);

  always_comb begin
    prefix_pos_nxt = prefix_pos_r;
    cands_nxt      = cands_r;
    field_nxt      = field_r;
    conv_nxt       = conv_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_qty_nxt    = out_qty_r;
    out_val_nxt    = out_val_r;

    if (in_fire) begin
      if (prefix_pos_r < nmeafx_pkg::PrefixLen) begin
        // Prefix matching: drop every candidate whose character differs.
        if (nmeafx_pkg::prefix_char(nmeafx_pkg::PrefixRmc, prefix_pos_r) != in_chan.data_byte)
          cands_nxt[0] = 1'b0;
        if (nmeafx_pkg::prefix_char(nmeafx_pkg::PrefixRmb, prefix_pos_r) != in_chan.data_byte)
          cands_nxt[1] = 1'b0;
        if (nmeafx_pkg::prefix_char(nmeafx_pkg::PrefixApb, prefix_pos_r) != in_chan.data_byte)
          cands_nxt[2] = 1'b0;
        prefix_pos_nxt = prefix_pos_r + 3'd1;
      end else if (cands_r != 3'b000) begin
        if (in_chan.data_byte == nmeafx_pkg::ChComma) begin
          // A comma closes the field: report it if chosen, then start afresh.
          if (qty_hit) begin
            out_valid_nxt = 1'b1;
            out_qty_nxt   = qty_sel;
            out_val_nxt   = signed_bits;
          end
          conv_nxt = '0;
          if (field_r != nmeafx_pkg::FieldMax)
            field_nxt = field_r + 4'd1;
        end else begin
          conv_nxt = conv_step;
        end
      end

      // The last character of a packet returns the parser to its start.
      if (in_chan.end_of_packet) begin
        prefix_pos_nxt = '0;
        cands_nxt      = 3'b111;
        field_nxt      = '0;
        conv_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_pos_r <= '0;
      cands_r      <= 3'b111;
      field_r      <= '0;
      conv_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      prefix_pos_r <= prefix_pos_nxt;
      cands_r      <= cands_nxt;
      field_r      <= field_nxt;
      conv_r       <= conv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    out_qty_r <= out_qty_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.quantity    = out_qty_r;
  assign out_chan.fixed_value = out_val_r;

`ifndef ASSERT_OFF
  // A pending result that is not being taken never coexists with an accepted character.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && out_valid_r && !out_chan.ready))
    else $error("input accepted while result register was stalled");

  // A new result only follows an accepted comma.
  a_result_from_comma: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_chan.ready) && out_valid_nxt |->
      (in_fire && in_chan.data_byte == nmeafx_pkg::ChComma))
    else $error("result produced without a closing comma");

  // The end of a packet returns prefix and field tracking to the start.
  a_eop_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.end_of_packet |=>
      (prefix_pos_r == 3'd0 && cands_r == 3'b111 && field_r == 4'd0))
    else $error("parser state not cleared after end of packet");

  // Within a packet, prefix candidates are only ever removed.
  a_cands_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_chan.end_of_packet |=> ((cands_r & ~$past(cands_r)) == 3'b000))
    else $error("prefix candidate reappeared within a packet");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench of the NMEA sentence field extractor: directed and random sentences, scoreboard check.
module tb;

  typedef struct {
    nmeafx_pkg::quantity_t qty;
    logic signed [31:0]    value;
  } field_result_t;

  // Scoreboard holding its own model of the parser and the fields it still expects.
  class field_scoreboard;
    field_result_t pending[$];
    int            errors;

    logic [47:0] prefix_tab[3];
    logic [2:0]  prefix_pos;
    logic [2:0]  candidates;
    logic [3:0]  field_num;
    logic [31:0] mag;
    logic [1:0]  frac_cnt;
    logic        frac_started;
    logic        neg;
    logic        stopped;
    logic        chars;

    function new();
      prefix_tab = '{nmeafx_pkg::PrefixRmc, nmeafx_pkg::PrefixRmb, nmeafx_pkg::PrefixApb};
      errors = 0;
      restart_packet();
    endfunction

    function void clear_field();
      mag = '0;
      frac_cnt = '0;
      frac_started = 1'b0;
      neg = 1'b0;
      stopped = 1'b0;
      chars = 1'b0;
    endfunction

    function void restart_packet();
      prefix_pos = '0;
      candidates = 3'b111;
      field_num = '0;
      clear_field();
    endfunction

    function void put_mag(logic [63:0] v);
      mag = (v > 64'(nmeafx_pkg::MagLimit)) ? nmeafx_pkg::MagLimit : v[31:0];
    endfunction

    // One character of a field; the accumulator counts thousandths.
    function void take_char(logic [7:0] ch);
      logic        first;
      logic [63:0] d;
      first = !chars;
      chars = 1'b1;
      if (stopped) return;
      d = 64'(ch - nmeafx_pkg::ChZero);
      if (ch >= nmeafx_pkg::ChZero && ch <= nmeafx_pkg::ChNine) begin
        if (!frac_started) begin
          put_mag(64'(mag) * 64'd10 + d * 64'd1000);
        end else if (frac_cnt != 2'd3) begin
          case (frac_cnt)
            2'd0:    put_mag(64'(mag) + d * 64'd100);
            2'd1:    put_mag(64'(mag) + d * 64'd10);
            default: put_mag(64'(mag) + d);
          endcase
          frac_cnt = frac_cnt + 2'd1;
        end
      end else if ((ch == nmeafx_pkg::ChPlus || ch == nmeafx_pkg::ChMinus) && first) begin
        neg = (ch == nmeafx_pkg::ChMinus);
      end else if (ch == nmeafx_pkg::ChDot && !frac_started) begin
        frac_started = 1'b1;
      end else begin
        stopped = 1'b1;
      end
    endfunction

    function bit pick_quantity(output nmeafx_pkg::quantity_t q);
      q = nmeafx_pkg::Q_GROUND_SPEED;
      if (candidates[0]) begin
        if (field_num == 4'd7) return 1'b1;
        q = nmeafx_pkg::Q_COURSE;
        if (field_num == 4'd8) return 1'b1;
      end else if (candidates[1]) begin
        q = nmeafx_pkg::Q_RANGE;
        if (field_num == 4'd10) return 1'b1;
        q = nmeafx_pkg::Q_CLOSING_VEL;
        if (field_num == 4'd12) return 1'b1;
      end else if (candidates[2]) begin
        q = nmeafx_pkg::Q_HEADING;
        if (field_num == 4'd13) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Called for every accepted input transaction.
    function void note_input(logic [7:0] ch, logic eop);
      field_result_t         res;
      nmeafx_pkg::quantity_t q;
      int                    hi;
      if (prefix_pos < nmeafx_pkg::PrefixLen) begin
        hi = 47 - 8 * int'(prefix_pos);
        for (int k = 0; k < 3; k++) begin
          if (prefix_tab[k][hi -: 8] != ch) candidates[k] = 1'b0;
        end
        prefix_pos = prefix_pos + 3'd1;
      end else if (candidates != 3'b000) begin
        if (ch == nmeafx_pkg::ChComma) begin
          if (pick_quantity(q)) begin
            res.qty = q;
            if (neg) res.value = -$signed(mag);
            else res.value = (mag > nmeafx_pkg::PosLimit) ? nmeafx_pkg::PosLimit : mag;
            pending.push_back(res);
          end
          clear_field();
          if (field_num < nmeafx_pkg::FieldMax) field_num = field_num + 4'd1;
        end else begin
          take_char(ch);
        end
      end
      if (eop) restart_packet();
    endfunction

    // Called for every accepted result transaction.
    function void check_result(logic [2:0] qty, logic signed [31:0] value);
      field_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: quantity %0d fixed_value %0d", qty, value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (qty !== want.qty) begin
        $error("quantity mismatch: expected %0d, actual %0d", want.qty, qty);
        errors++;
      end
      if (value !== want.value) begin
        $error("fixed_value mismatch: expected %0d, actual %0d", want.value, value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  nmeafx_in_if  in_if ();
  nmeafx_out_if out_if ();

  nmea_sentence_field_extractor_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  field_scoreboard sb;
  logic [7:0]      pkt[$];
  int              chars_sent = 0;
  int              src_idle_pct = 0;
  int              snk_idle_pct = 0;

  task automatic send_char(input logic [7:0] ch, input logic eop);
    if (chars_sent < 700) begin
      src_idle_pct = 27;
      snk_idle_pct = 77;
    end else if (chars_sent < 1400) begin
      src_idle_pct = 77;
      snk_idle_pct = 27;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= ch;
    in_if.end_of_packet <= eop;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.note_input(ch, eop);
    chars_sent++;
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt.size(); i++) send_char(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endfunction

  function automatic void add_commas(int n);
    repeat (n) pkt.push_back(nmeafx_pkg::ChComma);
  endfunction

  function automatic void add_digit();
    pkt.push_back(nmeafx_pkg::ChZero + 8'($urandom_range(9)));
  endfunction

  function automatic void add_prefix(logic [47:0] text);
    for (int i = 0; i < 6; i++) pkt.push_back(text[47 - 8 * i -: 8]);
  endfunction

  function automatic void add_junk();
    string junk;
    junk = "eE *.+-A#";
    if ($urandom_range(1) == 0) pkt.push_back(junk[$urandom_range(junk.len() - 1)]);
    else pkt.push_back(8'($urandom_range(255)));
  endfunction

  // Decimal text with an optional sign and fraction; long integer parts saturate.
  function automatic void add_number(bit long_int);
    if ($urandom_range(3) == 0)
      pkt.push_back($urandom_range(1) ? nmeafx_pkg::ChMinus : nmeafx_pkg::ChPlus);
    repeat (long_int ? $urandom_range(8, 13) : $urandom_range(0, 4)) add_digit();
    if ($urandom_range(99) < 60) begin
      pkt.push_back(nmeafx_pkg::ChDot);
      repeat ($urandom_range(0, 5)) add_digit();
    end
  endfunction

  function automatic void add_field(bit chosen);
    int r;
    r = $urandom_range(99);
    if (chosen) begin
      if (r < 8) return;
      add_number($urandom_range(9) == 0);
      if (r >= 70) begin
        add_junk();
        repeat ($urandom_range(0, 2)) add_digit();
      end
    end else if (r >= 65) begin
      add_number(1'b0);
    end
  endfunction

  // One random sentence: mostly a known prefix with enough fields to reach the chosen ones.
  task automatic send_random_sentence();
    logic [47:0] text;
    string       hexd;
    int          kind;
    int          last;
    int          nfields;
    bit          chosen;
    hexd = "0123456789ABCDEF";
    kind = $urandom_range(99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(255)));
      send_pkt();
      return;
    end
    case ($urandom_range(2))
      0:       begin text = nmeafx_pkg::PrefixRmc; last = 8;  end
      1:       begin text = nmeafx_pkg::PrefixRmb; last = 12; end
      default: begin text = nmeafx_pkg::PrefixApb; last = 13; end
    endcase
    if (kind >= 84) begin
      text[47 - 8 * $urandom_range(5) -: 8] =
        ($urandom_range(2) == 0) ? nmeafx_pkg::ChComma : 8'($urandom_range(255));
    end
    add_prefix(text);
    if ($urandom_range(99) < 80) nfields = $urandom_range(last + 1, 17);
    else nfields = $urandom_range(1, 17);
    for (int f = 1; f <= nfields; f++) begin
      pkt.push_back(nmeafx_pkg::ChComma);
      chosen = (text == nmeafx_pkg::PrefixRmc && (f == 7 || f == 8)) ||
               (text == nmeafx_pkg::PrefixRmb && (f == 10 || f == 12)) ||
               (text == nmeafx_pkg::PrefixApb && f == 13);
      add_field(chosen);
    end
    if ($urandom_range(99) < 70) begin
      add_text("*");
      pkt.push_back(hexd[$urandom_range(15)]);
      pkt.push_back(hexd[$urandom_range(15)]);
      add_text("\r\n");
    end else if (pkt.size() == 6) begin
      pkt.push_back(nmeafx_pkg::ChComma);
    end
    send_pkt();
  endtask

  // Result side: random back-pressure, every accepted transaction checked.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        sb.check_result(out_if.quantity, out_if.fixed_value);
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    sb = new();
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= 8'h00;
    in_if.end_of_packet <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ground speed with a fraction, negative course with a fourth fraction digit.
    add_text("$GPRMC"); add_commas(7); add_text("12.5,-359.9999,x"); send_pkt();
    // Positive saturation, then a lone sign followed by a dot.
    add_text("$ECRMB"); add_commas(10); add_text("99999999999,,+.,"); send_pkt();
    // Negative saturation, packet ending inside a later field.
    add_text("$ECAPB"); add_commas(13); add_text("-99999999999,9"); send_pkt();
    // Second dot and a sign after digits both stop conversion.
    add_text("$GPRMC"); add_commas(7); add_text("1.2.3,12-3,"); send_pkt();
    // Exponent and trailing space stop conversion.
    add_text("$ECAPB"); add_commas(13); add_text("1e5 ,,"); send_pkt();
    // Lone minus gives zero; a field closed by end of packet gives nothing.
    add_text("$GPRMC"); add_commas(7); add_text("-,+"); send_pkt();
    // Unknown prefix, and a comma inside the prefix.
    add_text("$GPRMB"); add_commas(7); add_text("5,"); send_pkt();
    add_text("$GP,MC"); add_commas(7); add_text("5,"); send_pkt();
    // Field counter saturates well past the chosen fields.
    add_text("$GPRMC"); add_commas(20); add_text("7,"); send_pkt();
    // Smallest negative step and the exact magnitude limit.
    add_text("$ECRMB"); add_commas(10); add_text("-000.001,,2147483.648,"); send_pkt();
    // Leading space, and a value made only of a fraction.
    add_text("$GPRMC"); add_commas(7); add_text(" 5,.5.,"); send_pkt();
    // Extreme byte values as a one-off packet.
    pkt.push_back(8'h00); pkt.push_back(8'hFF); send_pkt();

    while (chars_sent < 1850) send_random_sentence();
    in_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
